// ===== src/qbf_pkg.sv =====
// ----------------------------------------------------------------------------
// qbf_pkg: shared types and constants of the quadratic Bezier flattener
// Beat structs, fixed-point widths and the Q0.16 reciprocal table.
// ----------------------------------------------------------------------------
package qbf_pkg;

  localparam int CoordBits   = 20;
  localparam int MaxSegments = 32;
  localparam int CountBits   = 6;
  localparam int TBits       = 17;  // Q0.16 plus the value one
  localparam logic [TBits-1:0] TOne = 17'h10000;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] ctrl_x;
    logic signed [CoordBits-1:0] ctrl_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic [8:0]                  line_width;
    logic [31:0]                 line_color;
    logic [15:0]                 first_order;
  } curve_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] seg_x0;
    logic signed [CoordBits-1:0] seg_y0;
    logic signed [CoordBits-1:0] seg_x1;
    logic signed [CoordBits-1:0] seg_y1;
    logic [8:0]                  out_width;
    logic [31:0]                 out_color;
    logic [15:0]                 draw_order;
    logic                        last_segment;
  } segment_t;

  // R[n] = floor((65536 + n/2) / n), entry n at index n, entry 0 unused
  localparam logic [MaxSegments:0][TBits-1:0] RecipTab = {
    TBits'((65536 + 32 / 2) / 32),
    TBits'((65536 + 31 / 2) / 31),
    TBits'((65536 + 30 / 2) / 30),
    TBits'((65536 + 29 / 2) / 29),
    TBits'((65536 + 28 / 2) / 28),
    TBits'((65536 + 27 / 2) / 27),
    TBits'((65536 + 26 / 2) / 26),
    TBits'((65536 + 25 / 2) / 25),
    TBits'((65536 + 24 / 2) / 24),
    TBits'((65536 + 23 / 2) / 23),
    TBits'((65536 + 22 / 2) / 22),
    TBits'((65536 + 21 / 2) / 21),
    TBits'((65536 + 20 / 2) / 20),
    TBits'((65536 + 19 / 2) / 19),
    TBits'((65536 + 18 / 2) / 18),
    TBits'((65536 + 17 / 2) / 17),
    TBits'((65536 + 16 / 2) / 16),
    TBits'((65536 + 15 / 2) / 15),
    TBits'((65536 + 14 / 2) / 14),
    TBits'((65536 + 13 / 2) / 13),
    TBits'((65536 + 12 / 2) / 12),
    TBits'((65536 + 11 / 2) / 11),
    TBits'((65536 + 10 / 2) / 10),
    TBits'((65536 + 9 / 2) / 9),
    TBits'((65536 + 8 / 2) / 8),
    TBits'((65536 + 7 / 2) / 7),
    TBits'((65536 + 6 / 2) / 6),
    TBits'((65536 + 5 / 2) / 5),
    TBits'((65536 + 4 / 2) / 4),
    TBits'((65536 + 3 / 2) / 3),
    TBits'((65536 + 2 / 2) / 2),
    TBits'((65536 + 1 / 2) / 1),
    TBits'(0)
  };

endpackage

// ===== src/quadratic_bezier_flattener_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener_unit: uniform flattening of quadratic Beziers
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one curve per beat.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives N segments per
// curve, N = segment_count clamped to 1..32, last_segment on the final one.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes segment_count;
// write it only while the block is idle. Reset value is 12.
// A sequencer holds one curve and issues sample i = 1..N, one per cycle
// unless the receiver stalls, into a three-stage de Casteljau pipeline
// (t multiply, outer lerps, inner lerp), then an output register. The
// sequencer takes no new curve until it has issued all N samples of the
// current one; in_ready_o is low while it is busy.
// When the receiver stalls, the whole pipeline holds; nothing is lost.
// Reset clears all valid bits and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qbf_pkg::curve_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qbf_pkg::segment_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [5:0]        cfg_data_i
);
  localparam int CB = qbf_pkg::CoordBits;
  localparam int NB = qbf_pkg::CountBits;
  localparam int TB = qbf_pkg::TBits;

  typedef struct packed {
    logic [CB-1:0] p0x, p0y, cx, cy, p1x, p1y;
    logic [8:0]    width;
    logic [31:0]   color;
    logic [15:0]   order;
    logic          first;
    logic          last;
  } side_t;

  logic [NB-1:0] count_q;
  logic          busy_q;
  side_t         cur_q;
  logic [NB-1:0] idx_q, n_q;
  logic [TB-1:0] recip_q;

  logic          v1_q, v2_q, v3_q, vo_q;
  side_t         s1_d;
  side_t         s1_q, s2_q, s3_q;
  logic [TB-1:0] t1_q, t2_q;
  logic [CB-1:0] ax, bx, ay, by, px, py;
  logic [CB-1:0] prevx_q, prevy_q;
  logic [CB-1:0] nx, ny, sx, sy;
  qbf_pkg::segment_t out_q;
  logic          adv;
  logic [NB-1:0] n_clamp;
  logic [TB+NB-1:0] tmul;

  assign adv         = !vo_q || out_ready_i;
  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (count_q == '0) n_clamp = NB'(1);
    else if (count_q > NB'(qbf_pkg::MaxSegments)) n_clamp = NB'(qbf_pkg::MaxSegments);
    else n_clamp = count_q;
    tmul = (TB+NB)'(idx_q) * (TB+NB)'(recip_q);
    s1_d       = cur_q;
    s1_d.first = (idx_q == NB'(1));
    s1_d.last  = (idx_q == n_q);
  end

  // sequencer and stage 1: t = min(i*R, 1)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= NB'(12);
      busy_q  <= 1'b0;
      idx_q   <= '0;
      v1_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) count_q <= cfg_data_i;
      if (in_valid_i && !busy_q) begin
        busy_q <= 1'b1;
        idx_q  <= NB'(1);
      end else if (busy_q && adv) begin
        if (idx_q == n_q) busy_q <= 1'b0;
        idx_q <= idx_q + NB'(1);
      end
      if (adv) v1_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      cur_q.p0x   <= in_data_i.start_x ^ {1'b1, {CB-1{1'b0}}};
      cur_q.p0y   <= in_data_i.start_y ^ {1'b1, {CB-1{1'b0}}};
      cur_q.cx    <= in_data_i.ctrl_x ^ {1'b1, {CB-1{1'b0}}};
      cur_q.cy    <= in_data_i.ctrl_y ^ {1'b1, {CB-1{1'b0}}};
      cur_q.p1x   <= in_data_i.end_x ^ {1'b1, {CB-1{1'b0}}};
      cur_q.p1y   <= in_data_i.end_y ^ {1'b1, {CB-1{1'b0}}};
      cur_q.width <= in_data_i.line_width;
      cur_q.color <= in_data_i.line_color;
      cur_q.order <= in_data_i.first_order;
      cur_q.first <= 1'b0;
      cur_q.last  <= 1'b0;
      n_q         <= n_clamp;
      recip_q     <= qbf_pkg::RecipTab[n_clamp];
    end else if (busy_q && adv) begin
      cur_q.order <= cur_q.order + 16'd1;
    end
    if (adv) begin
      s1_q <= s1_d;
      t1_q <= (tmul > (TB+NB)'(qbf_pkg::TOne)) ? qbf_pkg::TOne : tmul[TB-1:0];
      s2_q <= s1_q;
      t2_q <= t1_q;
      s3_q <= s2_q;
    end
  end

  // stage 2: outer lerps, stage 3: inner lerp
  qbf_lerp u_ax (.clk_i, .en_i(adv), .p_i(s1_q.p0x), .q_i(s1_q.cx),  .t_i(t1_q), .r_o(ax));
  qbf_lerp u_bx (.clk_i, .en_i(adv), .p_i(s1_q.cx),  .q_i(s1_q.p1x), .t_i(t1_q), .r_o(bx));
  qbf_lerp u_ay (.clk_i, .en_i(adv), .p_i(s1_q.p0y), .q_i(s1_q.cy),  .t_i(t1_q), .r_o(ay));
  qbf_lerp u_by (.clk_i, .en_i(adv), .p_i(s1_q.cy),  .q_i(s1_q.p1y), .t_i(t1_q), .r_o(by));
  qbf_lerp u_px (.clk_i, .en_i(adv), .p_i(ax), .q_i(bx), .t_i(t2_q), .r_o(px));
  qbf_lerp u_py (.clk_i, .en_i(adv), .p_i(ay), .q_i(by), .t_i(t2_q), .r_o(py));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // output stage: chain previous sample, force the end point on the last
  always_comb begin
    nx = s3_q.last ? s3_q.p1x : px;
    ny = s3_q.last ? s3_q.p1y : py;
    sx = s3_q.first ? s3_q.p0x : prevx_q;
    sy = s3_q.first ? s3_q.p0y : prevy_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      out_q.seg_x0       <= sx ^ {1'b1, {CB-1{1'b0}}};
      out_q.seg_y0       <= sy ^ {1'b1, {CB-1{1'b0}}};
      out_q.seg_x1       <= nx ^ {1'b1, {CB-1{1'b0}}};
      out_q.seg_y1       <= ny ^ {1'b1, {CB-1{1'b0}}};
      out_q.out_width    <= s3_q.width;
      out_q.out_color    <= s3_q.color;
      out_q.draw_order   <= s3_q.order;
      out_q.last_segment <= s3_q.last;
      prevx_q <= nx;
      prevy_q <= ny;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o);
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o));
  a_no_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o);
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (n_q != '0 && n_q <= NB'(qbf_pkg::MaxSegments)));
endmodule

// ===== src/qbf_lerp.sv =====
// ----------------------------------------------------------------------------
// qbf_lerp: one registered linear interpolation step
// r = (p*(1-t) + q*t + half) >> 16 on offset-binary coordinates, saturated.
// ----------------------------------------------------------------------------
module qbf_lerp (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [qbf_pkg::CoordBits-1:0]  p_i,
  input  logic [qbf_pkg::CoordBits-1:0]  q_i,
  input  logic [qbf_pkg::TBits-1:0]      t_i,
  output logic [qbf_pkg::CoordBits-1:0]  r_o
);
  localparam int W = qbf_pkg::CoordBits + qbf_pkg::TBits + 1;

  logic [qbf_pkg::TBits-1:0] tc;
  logic [W-1:0]              sum;
  logic [W-17:0]             shr;
  logic [qbf_pkg::CoordBits-1:0] r_d, r_q;

  always_comb begin
    tc  = qbf_pkg::TOne - t_i;
    sum = W'(p_i) * W'(tc) + W'(q_i) * W'(t_i) + W'(32768);
    shr = sum[W-1:16];
    if (shr > (W-16)'({qbf_pkg::CoordBits{1'b1}})) r_d = '1;
    else r_d = shr[qbf_pkg::CoordBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_d;
  end

  assign r_o = r_q;
endmodule
